@@ src/gdd_pkg.sv @@
package gdd_pkg;

   // Field widths of one transaction.
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int DIST_W  = 22;

   // Calendar constants.
   localparam logic [YEAR_W-1:0] MAX_YEAR      = YEAR_W'(9999);
   localparam int                DAYS_PER_YEAR = 365;
   localparam int                MONTH_MAR     = 3;
   localparam int                MONTH_DEC     = 12;

   // Widths of the intermediate values.
   localparam int YEAR_P_W = YEAR_W + 1;   // year plus a small offset
   localparam int Q100_W   = 7;            // quotient of a year by 100
   localparam int Q400_W   = 5;            // quotient of a year by 400
   localparam int LEAPS_W  = 12;           // leap years below a year
   localparam int DOY_W    = 9;            // day of year
   localparam int REST_W   = 14;           // signed sum of the small terms
   localparam int TOTAL_W  = DIST_W + 2;   // signed full distance

   // Division by 100 and 400 as a multiplication by a scaled reciprocal.
   // Both are exact for every dividend below 2^15.
   localparam int PROD_W     = 30;
   localparam int RECIP_100  = 10486;
   localparam int SHIFT_100  = 20;
   localparam int RECIP_400  = 10486;
   localparam int SHIFT_400  = 22;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // Days in the months before a given month; codes outside 1..12 have none.
   localparam logic [DOY_W-1:0] MONTHS_BEFORE [16] = '{
      9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
   };

   // Load enables of two consecutive pipeline stages inside one unit.
   typedef struct packed {
      logic first;
      logic second;
   } gdd_stage_en_type;

endpackage

@@ src/gdd_if.sv @@
interface gdd_req_if import gdd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  year_a;
   logic [MONTH_W-1:0] month_a;
   logic [DAY_W-1:0]   day_a;
   logic [YEAR_W-1:0]  year_b;
   logic [MONTH_W-1:0] month_b;
   logic [DAY_W-1:0]   day_b;

   modport source (output valid, year_a, month_a, day_a, year_b, month_b, day_b,
                   input ready);
   modport sink (input valid, year_a, month_a, day_a, year_b, month_b, day_b,
                 output ready);
endinterface

interface gdd_rsp_if import gdd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] day_distance;

   modport source (output valid, day_distance, input ready);
   modport sink (input valid, day_distance, output ready);
endinterface

@@ src/gdd_order.sv @@
module gdd_order import gdd_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [YEAR_W-1:0]  year_a,
   input  logic [MONTH_W-1:0] month_a,
   input  logic [DAY_W-1:0]   day_a,
   input  logic [YEAR_W-1:0]  year_b,
   input  logic [MONTH_W-1:0] month_b,
   input  logic [DAY_W-1:0]   day_b,
   output logic [YEAR_W-1:0]  later_year,
   output logic [MONTH_W-1:0] later_month,
   output logic [DAY_W-1:0]   later_day,
   output logic [YEAR_W-1:0]  earlier_year,
   output logic [MONTH_W-1:0] earlier_month,
   output logic [DAY_W-1:0]   earlier_day
);

   logic [YEAR_W-1:0]  ya_clamp, yb_clamp;
   logic               a_later;
   logic [YEAR_W-1:0]  l_year_in, e_year_in, l_year_ff, e_year_ff;
   logic [MONTH_W-1:0] l_month_in, e_month_in, l_month_ff, e_month_ff;
   logic [DAY_W-1:0]   l_day_in, e_day_in, l_day_ff, e_day_ff;

   // Clamp both years, then order the dates as year, month, day.
   always_comb begin
      ya_clamp = (year_a > MAX_YEAR) ? MAX_YEAR : year_a;
      yb_clamp = (year_b > MAX_YEAR) ? MAX_YEAR : year_b;
      a_later  = {ya_clamp, month_a, day_a} > {yb_clamp, month_b, day_b};
      if (a_later) begin
         l_year_in = ya_clamp; l_month_in = month_a; l_day_in = day_a;
         e_year_in = yb_clamp; e_month_in = month_b; e_day_in = day_b;
      end else begin
         l_year_in = yb_clamp; l_month_in = month_b; l_day_in = day_b;
         e_year_in = ya_clamp; e_month_in = month_a; e_day_in = day_a;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l_year_ff  <= l_year_in;
         l_month_ff <= l_month_in;
         l_day_ff   <= l_day_in;
         e_year_ff  <= e_year_in;
         e_month_ff <= e_month_in;
         e_day_ff   <= e_day_in;
      end
   end

   assign later_year    = l_year_ff;
   assign later_month   = l_month_ff;
   assign later_day     = l_day_ff;
   assign earlier_year  = e_year_ff;
   assign earlier_month = e_month_ff;
   assign earlier_day   = e_day_ff;

endmodule

@@ src/gdd_calendar.sv @@
module gdd_calendar import gdd_pkg::*; (
   input  logic               clock,
   input  gdd_stage_en_type   en,
   input  logic [YEAR_W-1:0]  year,
   input  logic [MONTH_W-1:0] month,
   input  logic [DAY_W-1:0]   day,
   output logic [YEAR_W-1:0]  year_out,
   output logic [LEAPS_W-1:0] leaps_below,
   output logic [DOY_W-1:0]   day_of_year
);

   logic [PROD_W-1:0]  p100c, p100f, p400c, p400f;
   logic [Q100_W-1:0]  q100c_in, q100f_in, q100c_ff, q100f_ff;
   logic [Q400_W-1:0]  q400c_in, q400f_in, q400c_ff, q400f_ff;
   logic [YEAR_W-1:0]  year_a_ff, year_b_ff;
   logic [MONTH_W-1:0] month_ff;
   logic [DAY_W-1:0]   day_ff;

   logic [YEAR_P_W-1:0] c4;
   logic [YEAR_P_W-1:0] leaps_wide;
   logic                leap;
   logic [LEAPS_W-1:0]  leaps_in, leaps_ff;
   logic [DOY_W-1:0]    doy_in, doy_ff;

   // First stage: rounded-up and rounded-down quotients by 100 and 400.
   always_comb begin
      p100c = (PROD_W'(year) + PROD_W'(99))  * PROD_W'(RECIP_100);
      p100f =  PROD_W'(year)                 * PROD_W'(RECIP_100);
      p400c = (PROD_W'(year) + PROD_W'(399)) * PROD_W'(RECIP_400);
      p400f =  PROD_W'(year)                 * PROD_W'(RECIP_400);
      q100c_in = p100c[SHIFT_100 +: Q100_W];
      q100f_in = p100f[SHIFT_100 +: Q100_W];
      q400c_in = p400c[SHIFT_400 +: Q400_W];
      q400f_in = p400f[SHIFT_400 +: Q400_W];
   end

   always_ff @(posedge clock) begin
      if (en.first) begin
         q100c_ff  <= q100c_in;
         q100f_ff  <= q100f_in;
         q400c_ff  <= q400c_in;
         q400f_ff  <= q400f_in;
         year_a_ff <= year;
         month_ff  <= month;
         day_ff    <= day;
      end
   end

   // Second stage: leap years below the year, leap flag and day of year.
   // A year divides by 100 exactly when both roundings agree; same for 400.
   always_comb begin
      c4         = (YEAR_P_W'(year_a_ff) + YEAR_P_W'(3)) >> 2;
      leaps_wide = c4 - YEAR_P_W'(q100c_ff) + YEAR_P_W'(q400c_ff);
      leaps_in   = leaps_wide[LEAPS_W-1:0];
      leap       = ((year_a_ff[1:0] == 2'b00) && (q100c_ff != q100f_ff))
                   || (q400c_ff == q400f_ff);
      doy_in     = DOY_W'(day_ff) + MONTHS_BEFORE[month_ff];
      if (leap && (month_ff >= MONTH_W'(MONTH_MAR)) && (month_ff <= MONTH_W'(MONTH_DEC))) begin
         doy_in = doy_in + DOY_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (en.second) begin
         leaps_ff  <= leaps_in;
         doy_ff    <= doy_in;
         year_b_ff <= year_a_ff;
      end
   end

   assign year_out    = year_b_ff;
   assign leaps_below = leaps_ff;
   assign day_of_year = doy_ff;

endmodule

@@ src/gdd_sum.sv @@
module gdd_sum import gdd_pkg::*; (
   input  logic               clock,
   input  gdd_stage_en_type   en,
   input  logic [YEAR_W-1:0]  later_year,
   input  logic [LEAPS_W-1:0] later_leaps,
   input  logic [DOY_W-1:0]   later_doy,
   input  logic [YEAR_W-1:0]  earlier_year,
   input  logic [LEAPS_W-1:0] earlier_leaps,
   input  logic [DOY_W-1:0]   earlier_doy,
   output logic [DIST_W-1:0]  distance
);

   logic [YEAR_W-1:0]        year_diff;
   logic [DIST_W-1:0]        years_in, years_ff;
   logic signed [REST_W-1:0] rest_in, rest_ff;
   logic signed [TOTAL_W-1:0] total;
   logic [DIST_W-1:0]        dist_in, dist_ff;

   // First stage: whole years times 365, and the small correction terms.
   always_comb begin
      year_diff = later_year - earlier_year;
      years_in  = DIST_W'(year_diff * DIST_W'(DAYS_PER_YEAR));
      rest_in   = $signed(REST_W'(later_leaps)) - $signed(REST_W'(earlier_leaps))
                + $signed(REST_W'(later_doy)) - $signed(REST_W'(earlier_doy));
   end

   always_ff @(posedge clock) begin
      if (en.first) begin
         years_ff <= years_in;
         rest_ff  <= rest_in;
      end
   end

   // Second stage: final add and saturation to the output range.
   always_comb begin
      total = $signed(TOTAL_W'(years_ff)) + TOTAL_W'(rest_ff);
      priority if (total < 0) begin
         dist_in = '0;
      end else if (total > $signed(TOTAL_W'(DIST_MAX))) begin
         dist_in = DIST_MAX;
      end else begin
         dist_in = total[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.second) begin
         dist_ff <= dist_in;
      end
   end

   assign distance = dist_ff;

endmodule

@@ src/gregorian_date_distance_unit.sv @@
// Days between two Gregorian dates. Each request transaction carries two dates
// in either order; the response transaction gives the absolute number of days
// between them. Years above 9999 are treated as 9999, year zero counts as a
// leap year, and a month code outside 1..12 contributes no preceding months.
// The unit is a five-stage pipeline: ordering, reciprocal division of the
// years, leap count and day of year, year product, final sum. It takes one
// transaction per cycle while req.ready is high. A result is offered once it
// reaches the last stage, and it leaves when the response side is ready.
// The last stage is the output register, so req.ready drops only when every
// stage holds an item and the response side is stalled.
module gregorian_date_distance_unit import gdd_pkg::*; (
   input logic       clock,
   input logic       reset,
   gdd_req_if.sink   req,
   gdd_rsp_if.source rsp
);

   localparam int STAGES = 5;

   logic [STAGES:1]   vld_ff, vld_in;
   logic [STAGES+1:1] rdy;

   logic [YEAR_W-1:0]  l_year1, e_year1, l_year3, e_year3;
   logic [MONTH_W-1:0] l_month1, e_month1;
   logic [DAY_W-1:0]   l_day1, e_day1;
   logic [LEAPS_W-1:0] l_leaps3, e_leaps3;
   logic [DOY_W-1:0]   l_doy3, e_doy3;

   gdd_stage_en_type cal_en, sum_en;

   // Each stage loads when it is empty or its successor moves on.
   always_comb begin
      rdy[STAGES+1] = rsp.ready;
      for (int k = STAGES; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[1] = rdy[1] ? req.valid : vld_ff[1];
      for (int k = 2; k <= STAGES; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign cal_en.first  = rdy[2];
   assign cal_en.second = rdy[3];
   assign sum_en.first  = rdy[4];
   assign sum_en.second = rdy[5];

   assign req.ready = rdy[1];
   assign rsp.valid = vld_ff[STAGES];

   gdd_order u_order (
      .clock         (clock),
      .en            (rdy[1]),
      .year_a        (req.year_a),
      .month_a       (req.month_a),
      .day_a         (req.day_a),
      .year_b        (req.year_b),
      .month_b       (req.month_b),
      .day_b         (req.day_b),
      .later_year    (l_year1),
      .later_month   (l_month1),
      .later_day     (l_day1),
      .earlier_year  (e_year1),
      .earlier_month (e_month1),
      .earlier_day   (e_day1)
   );

   gdd_calendar u_cal_later (
      .clock       (clock),
      .en          (cal_en),
      .year        (l_year1),
      .month       (l_month1),
      .day         (l_day1),
      .year_out    (l_year3),
      .leaps_below (l_leaps3),
      .day_of_year (l_doy3)
   );

   gdd_calendar u_cal_earlier (
      .clock       (clock),
      .en          (cal_en),
      .year        (e_year1),
      .month       (e_month1),
      .day         (e_day1),
      .year_out    (e_year3),
      .leaps_below (e_leaps3),
      .day_of_year (e_doy3)
   );

   gdd_sum u_sum (
      .clock         (clock),
      .en            (sum_en),
      .later_year    (l_year3),
      .later_leaps   (l_leaps3),
      .later_doy     (l_doy3),
      .earlier_year  (e_year3),
      .earlier_leaps (e_leaps3),
      .earlier_doy   (e_doy3),
      .distance      (rsp.day_distance)
   );

endmodule

@@ src/gdd_checker.sv @@
module gdd_checker import gdd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DIST_W-1:0] rsp_day_distance
);

   // A pending response stays offered until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn before acceptance");

   // A stalled response keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_day_distance))
      else $error("stalled response changed");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered straight after reset");

   // With the response side open, every stage moves, so requests are taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request refused while the response side is open");

   // An accepted transaction passes through every stage and is offered at the
   // output when the response side stays ready behind it.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
      ##1 rsp_ready |=> rsp_valid)
      else $error("transaction lost in the pipeline");

endmodule

bind gregorian_date_distance_unit gdd_checker u_gdd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_day_distance (rsp.day_distance)
);
